// ----- sv/lsrp_pkg.sv -----
// Shared types and constants for the laser scan reply parser.
// No dependencies; every other file of the block but lsrp_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lsrp_pkg;

  // Characters of the reply format
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Byte position of the LF that closes the header
  localparam logic [6:0] HEADER_LAST = 7'd22;

  // Widths fixed by the result fields
  localparam int STEP_W = 14;
  localparam int DIST_W = 12;
  localparam int SIX_W  = 6;

  // A block holds at most 64 bytes, so at most 32 values: count field width
  localparam int MAX_BLOCK_BYTES = 64;
  localparam int CNT_W = $clog2((MAX_BLOCK_BYTES + 1) / 2 + 1);

  // Result kinds
  typedef enum logic [2:0] {
    KIND_POINT    = 3'd0,
    KIND_DONE     = 3'd1,
    KIND_HEADER   = 3'd2,
    KIND_CHECKSUM = 3'd3,
    KIND_FRAMING  = 3'd4
  } kind_t;

  // Command from front to back: one single result, or the release of a block
  typedef struct packed {
    kind_t              kind;   // KIND_POINT means block release
    logic [STEP_W-1:0]  base;   // step index of the first point of the block
    logic [CNT_W-1:0]   count;  // number of points in the block
    logic               bank;   // value buffer bank that holds the block
  } cmd_t;

  // Back to front: a value bank has been drained
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_free_t;

endpackage

`default_nettype wire

// ----- sv/laser_scan_reply_parser.sv -----
// Laser scan reply parser, top level: byte front end, command queue, value
// bank RAM and result back end. Depends on lsrp_pkg and all lsrp_* modules.
//
// Takes a rangefinder "GS" scan reply one byte per transfer and delivers
// points (step index and 12-bit distance), frame-complete and error results,
// each with last set on the final result caused by its byte. The input
// reports full while the two-entry command queue is full, or while a data
// byte would go to a value bank whose block is still being delivered. Points
// of a checked block leave one at a time, paced by the registered RAM read
// feeding the single output register; the next value is read only after the
// previous read has landed. The two banks let one block be received while
// the previous one drains. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module laser_scan_reply_parser #(
  parameter int BLOCK_BYTES = 64,
  parameter int MAX_POINTS  = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       kind,
  output logic [13:0]      step_index,
  output logic [11:0]      distance,
  output logic             last
);

  import lsrp_pkg::*;

  localparam int SLOTS  = (BLOCK_BYTES + 1) / 2;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cmd_t              front_cmd;
  cmd_t              back_cmd;
  logic              cmd_wr;
  logic              cmd_rd;
  logic              cmd_full;
  logic              cmd_valid;
  bank_free_t        bank_free;
  logic              ram_wr;
  logic [SLOT_W:0]   ram_wr_addr;
  logic [DIST_W-1:0] ram_wr_data;
  logic [SLOT_W:0]   ram_rd_addr;
  logic [DIST_W-1:0] ram_rd_data;

  // Byte parsing and checks
  lsrp_front #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_POINTS  (MAX_POINTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .full      (full),
    .cmd_wr    (cmd_wr),
    .cmd       (front_cmd),
    .cmd_full  (cmd_full),
    .bank_free (bank_free),
    .ram_wr    (ram_wr),
    .ram_addr  (ram_wr_addr),
    .ram_data  (ram_wr_data)
  );

  // Command queue
  lsrp_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_wr),
    .wr_cmd (front_cmd),
    .full   (cmd_full),
    .rd_en  (cmd_rd),
    .rd_cmd (back_cmd),
    .valid  (cmd_valid)
  );

  // Two banks of block values
  lsrp_ram #(
    .WIDTH (DIST_W),
    .DEPTH (2 * (2 ** SLOT_W))
  ) u_values (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Result delivery
  lsrp_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (back_cmd),
    .cmd_valid  (cmd_valid),
    .cmd_rd     (cmd_rd),
    .ram_addr   (ram_rd_addr),
    .ram_data   (ram_rd_data),
    .bank_free  (bank_free),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .step_index (step_index),
    .distance   (distance),
    .last       (last)
  );

endmodule

`default_nettype wire

// ----- sv/lsrp_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lsrp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- sv/lsrp_cmd_fifo.sv -----
// Two-entry command queue between the byte front end and the result back end.
// Depends on lsrp_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module lsrp_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire lsrp_pkg::cmd_t wr_cmd,
  output logic               full,
  input  wire logic          rd_en,
  output lsrp_pkg::cmd_t     rd_cmd,
  output logic               valid
);

  import lsrp_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign valid  = (count != 2'd0);
  assign rd_cmd = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lsrp_front.sv -----
// Byte front end: header, data, checksum and framing checks of a scan reply.
// Writes decoded values to the bank RAM and queues commands; uses lsrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsrp_front #(
  parameter int BLOCK_BYTES = 64,
  parameter int MAX_POINTS  = 1024,
  localparam int SLOTS  = (BLOCK_BYTES + 1) / 2,
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire logic [7:0]          rx_byte,
  output logic                     full,
  output logic                     cmd_wr,
  output lsrp_pkg::cmd_t           cmd,
  input  wire logic                cmd_full,
  input  wire lsrp_pkg::bank_free_t bank_free,
  output logic                     ram_wr,
  output logic [SLOT_W:0]          ram_addr,
  output logic [lsrp_pkg::DIST_W-1:0] ram_data
);

  import lsrp_pkg::*;

  localparam int BL_W   = $clog2(2 * MAX_POINTS + 1);
  localparam int PC_W   = $clog2(MAX_POINTS + 1);
  localparam logic [6:0]  BLOCK_LEN = 7'(BLOCK_BYTES);
  localparam logic [STEP_W-1:0] MAX_SPAN = STEP_W'(MAX_POINTS);

  typedef enum logic [2:0] {
    PH_HUNT_G   = 3'd0,
    PH_HEADER   = 3'd1,
    PH_DATA     = 3'd2,
    PH_CHECK    = 3'd3,
    PH_BLOCK_LF = 3'd4,
    PH_END_LF   = 3'd5,
    PH_HUNT_LF  = 3'd6
  } phase_t;

  phase_t            phase, phase_next;
  logic [6:0]        byte_position, byte_position_next;
  logic [STEP_W-1:0] first_step, first_step_next;
  logic [STEP_W-1:0] final_step, final_step_next;
  logic [BL_W-1:0]   bytes_left, bytes_left_next;
  logic [SIX_W-1:0]  running_sum, running_sum_next;
  logic [SIX_W-1:0]  high_sixbits, high_sixbits_next;
  logic [PC_W-1:0]   point_counter, point_counter_next;
  logic [CNT_W-1:0]  block_fill, block_fill_next;
  logic              previous_was_lf, previous_was_lf_next;
  logic              bank, bank_next;
  logic [1:0]        bank_busy, bank_busy_next;

  logic              accept;
  logic              is_lf;
  logic              is_digit;
  logic [3:0]        digit;
  logic [STEP_W-1:0] final_new;
  logic [STEP_W-1:0] span;
  logic [SIX_W-1:0]  six;
  logic [6:0]        pos_inc;
  logic [7:0]        check_char;
  logic [STEP_W-1:0] block_base;

  // Stall on a full queue, or on data bytes while the target bank drains
  assign full   = cmd_full || ((phase == PH_DATA) && bank_busy[bank]);
  assign accept = push && !full;

  assign is_lf      = (rx_byte == CH_LF);
  assign is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit      = rx_byte[3:0];
  assign final_new  = STEP_W'((final_step << 3) + (final_step << 1) + STEP_W'(digit));
  assign span       = final_new - first_step;
  assign six        = SIX_W'(rx_byte - CH_ZERO);
  assign pos_inc    = byte_position + 7'd1;
  assign check_char = {2'b00, running_sum} + CH_ZERO;
  assign block_base = first_step + STEP_W'(point_counter) - STEP_W'(block_fill);

  assign ram_data = {high_sixbits, six};
  assign ram_addr = {bank, block_fill[SLOT_W-1:0]};

  // Next state for one accepted byte, plus bank release from the back end
  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    first_step_next      = first_step;
    final_step_next      = final_step;
    bytes_left_next      = bytes_left;
    running_sum_next     = running_sum;
    high_sixbits_next    = high_sixbits;
    point_counter_next   = point_counter;
    block_fill_next      = block_fill;
    previous_was_lf_next = previous_was_lf;
    bank_next            = bank;
    bank_busy_next       = bank_busy;
    cmd_wr               = 1'b0;
    cmd                  = '{kind: KIND_DONE, base: '0, count: '0, bank: 1'b0};
    ram_wr               = 1'b0;

    if (bank_free.valid) begin
      bank_busy_next[bank_free.bank] = 1'b0;
    end

    if (accept) begin
      case (phase)
        PH_HEADER: begin
          byte_position_next = pos_inc;
          if (byte_position == 7'd1) begin
            if (rx_byte != CH_S) begin
              cmd_wr   = 1'b1;
              cmd.kind = KIND_HEADER;
            end
          end else if (byte_position >= 7'd2 && byte_position <= 7'd9) begin
            if (!is_digit) begin
              cmd_wr   = 1'b1;
              cmd.kind = KIND_HEADER;
            end else if (byte_position <= 7'd5) begin
              first_step_next = STEP_W'((first_step << 3) + (first_step << 1)
                                        + STEP_W'(digit));
            end else begin
              final_step_next = final_new;
              if (byte_position == 7'd9) begin
                if (final_new < first_step || span >= MAX_SPAN) begin
                  cmd_wr   = 1'b1;
                  cmd.kind = KIND_HEADER;
                end
                bytes_left_next = BL_W'({span, 1'b0} + 2);
              end
            end
          end else if (byte_position >= HEADER_LAST) begin
            if (!is_lf) begin
              cmd_wr   = 1'b1;
              cmd.kind = KIND_HEADER;
            end else begin
              phase_next         = PH_DATA;
              point_counter_next = '0;
              byte_position_next = '0;
              running_sum_next   = '0;
              block_fill_next    = '0;
            end
          end
        end

        PH_DATA: begin
          running_sum_next = SIX_W'(running_sum + SIX_W'(rx_byte));
          if (!bytes_left[0]) begin
            high_sixbits_next = six;
          end else begin
            ram_wr             = 1'b1;
            block_fill_next    = block_fill + CNT_W'(1);
            point_counter_next = point_counter + PC_W'(1);
          end
          if (bytes_left != '0) begin
            bytes_left_next = bytes_left - BL_W'(1);
          end
          byte_position_next = pos_inc;
          if (pos_inc >= BLOCK_LEN || bytes_left_next == '0) begin
            phase_next = PH_CHECK;
          end
        end

        PH_CHECK: begin
          if (rx_byte != check_char) begin
            cmd_wr   = 1'b1;
            cmd.kind = KIND_CHECKSUM;
          end else begin
            phase_next = PH_BLOCK_LF;
            if (block_fill != '0) begin
              cmd_wr    = 1'b1;
              cmd.kind  = KIND_POINT;
              cmd.base  = block_base;
              cmd.count = block_fill;
              cmd.bank  = bank;
              bank_busy_next[bank] = 1'b1;
              bank_next = ~bank;
            end
          end
        end

        PH_BLOCK_LF: begin
          if (!is_lf) begin
            cmd_wr   = 1'b1;
            cmd.kind = KIND_FRAMING;
          end else if (bytes_left == '0) begin
            phase_next = PH_END_LF;
          end else begin
            phase_next         = PH_DATA;
            byte_position_next = '0;
            running_sum_next   = '0;
            block_fill_next    = '0;
          end
        end

        PH_END_LF: begin
          cmd_wr = 1'b1;
          if (!is_lf) begin
            cmd.kind = KIND_FRAMING;
          end else begin
            cmd.kind   = KIND_DONE;
            phase_next = PH_HUNT_G;
          end
        end

        PH_HUNT_LF: begin
          if (is_lf && previous_was_lf) begin
            phase_next           = PH_HUNT_G;
            previous_was_lf_next = 1'b0;
          end else begin
            previous_was_lf_next = is_lf;
          end
        end

        default: begin
          phase_next = PH_HUNT_G;
          if (rx_byte == CH_G) begin
            phase_next         = PH_HEADER;
            byte_position_next = 7'd1;
            first_step_next    = '0;
            final_step_next    = '0;
          end
        end
      endcase

      // Any error result sends the parser hunting for LF LF
      if (cmd_wr && cmd.kind != KIND_POINT && cmd.kind != KIND_DONE) begin
        phase_next           = PH_HUNT_LF;
        previous_was_lf_next = is_lf;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT_G;
      byte_position   <= '0;
      first_step      <= '0;
      final_step      <= '0;
      bytes_left      <= '0;
      running_sum     <= '0;
      high_sixbits    <= '0;
      point_counter   <= '0;
      block_fill      <= '0;
      previous_was_lf <= 1'b0;
      bank            <= 1'b0;
      bank_busy       <= '0;
    end else begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      first_step      <= first_step_next;
      final_step      <= final_step_next;
      bytes_left      <= bytes_left_next;
      running_sum     <= running_sum_next;
      high_sixbits    <= high_sixbits_next;
      point_counter   <= point_counter_next;
      block_fill      <= block_fill_next;
      previous_was_lf <= previous_was_lf_next;
      bank            <= bank_next;
      bank_busy       <= bank_busy_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lsrp_back.sv -----
// Result back end: turns queued commands into results, reading block values
// from the bank RAM one point at a time. Uses lsrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsrp_back #(
  parameter int BLOCK_BYTES = 64,
  localparam int SLOTS  = (BLOCK_BYTES + 1) / 2,
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire lsrp_pkg::cmd_t         cmd,
  input  wire logic                   cmd_valid,
  output logic                        cmd_rd,
  output logic [SLOT_W:0]             ram_addr,
  input  wire logic [lsrp_pkg::DIST_W-1:0] ram_data,
  output lsrp_pkg::bank_free_t        bank_free,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [2:0]                  kind,
  output logic [lsrp_pkg::STEP_W-1:0] step_index,
  output logic [lsrp_pkg::DIST_W-1:0] distance,
  output logic                        last
);

  import lsrp_pkg::*;

  logic              out_valid;
  logic              draining;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  count;
  logic [STEP_W-1:0] base;
  logic              bank;
  logic              rd_pend;
  logic              rd_last;
  logic              rd_bank;
  logic [STEP_W-1:0] rd_step;

  logic              out_free;
  logic              issue;
  logic              take_cmd;
  logic              take_single;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  // Read a value when the output register will be free on its arrival
  assign issue    = draining && !rd_pend && out_free;
  assign take_cmd = !draining && !rd_pend && cmd_valid
                    && ((cmd.kind == KIND_POINT) || out_free);
  assign take_single = take_cmd && (cmd.kind != KIND_POINT);
  assign cmd_rd   = take_cmd;

  assign ram_addr = {bank, idx[SLOT_W-1:0]};

  assign bank_free.valid = rd_pend && rd_last;
  assign bank_free.bank  = rd_bank;

  // Drain sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      draining  <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (rd_pend || take_single) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (take_cmd && cmd.kind == KIND_POINT) begin
        draining <= 1'b1;
      end else if (issue && idx == count - CNT_W'(1)) begin
        draining <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (take_cmd) begin
      idx   <= '0;
      count <= cmd.count;
      base  <= cmd.base;
      bank  <= cmd.bank;
    end else if (issue) begin
      idx <= idx + CNT_W'(1);
    end
    if (issue) begin
      rd_last <= (idx == count - CNT_W'(1));
      rd_bank <= bank;
      rd_step <= base + STEP_W'(idx);
    end
    if (rd_pend) begin
      kind       <= KIND_POINT;
      step_index <= rd_step;
      distance   <= ram_data;
      last       <= rd_last;
    end else if (take_single) begin
      kind       <= cmd.kind;
      step_index <= '0;
      distance   <= '0;
      last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the laser scan reply parser: byte driver, result
// receiver and a scoreboard that predicts every result. Depends on lsrp_pkg.
`timescale 1ns / 1ps

module tb_top;
  import lsrp_pkg::*;

  localparam int BLOCK_BYTES = 64;
  localparam int MAX_POINTS  = 1024;
  localparam int BYTE_TARGET = 420;
  localparam int LONG_HOLD   = 600;
  localparam int DRAIN_LIMIT = 50000;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {
    ST_HUNT_G, ST_HEADER, ST_DATA, ST_CHECK, ST_BLOCK_LF, ST_END_LF, ST_HUNT_LF
  } parse_phase_t;

  typedef enum int {
    FLT_NONE, FLT_NOT_S, FLT_BAD_DIGIT, FLT_STEP_ORDER, FLT_TOO_MANY,
    FLT_HEADER_LF, FLT_CHECKSUM, FLT_BLOCK_LF, FLT_END_LF
  } frame_fault_t;

  typedef struct packed {
    kind_t              kind;
    logic [STEP_W-1:0]  step;
    logic [DIST_W-1:0]  dval;
    logic               last;
  } scan_result_t;

  // Tracks the parser state byte by byte and holds the results still owed
  class scan_scoreboard;
    scan_result_t pending_results[$];
    scan_result_t batch[$];
    int           errors;
    int           kind_seen[5];
    parse_phase_t phase;
    int unsigned  pos, first_step, final_step, bytes_left, point_count, fill;
    bit [5:0]     run_sum, high_six;
    bit [11:0]    vals[32];
    bit           prev_lf;

    function new();
      phase = ST_HUNT_G;
      pos = 0; first_step = 0; final_step = 0; bytes_left = 0;
      point_count = 0; fill = 0; run_sum = 0; high_six = 0; prev_lf = 0;
      errors = 0;
    endfunction

    function void add_result(kind_t k, int unsigned step, bit [11:0] dval);
      scan_result_t r;
      r.kind = k;
      r.step = step[STEP_W-1:0];
      r.dval = dval;
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    // Any error drops to the LF LF hunt; the error byte itself may be the first LF
    function void abandon(kind_t k, bit [7:0] b);
      phase = ST_HUNT_LF;
      prev_lf = (b == CH_LF);
      add_result(k, 0, 0);
    endfunction

    function void start_block();
      pos = 0;
      run_sum = 0;
      fill = 0;
    endfunction

    // Called on every byte transfer
    function void note_byte(bit [7:0] b);
      bit [7:0]     d;
      bit [5:0]     six;
      int unsigned  n, base;
      scan_result_t r;
      batch = {};
      case (phase)
        ST_HEADER: begin
          if (pos == 1 && b != CH_S) begin
            abandon(KIND_HEADER, b);
          end else if (pos >= 2 && pos <= 9) begin
            if (b < CH_ZERO || b > CH_NINE) begin
              abandon(KIND_HEADER, b);
            end else begin
              if (pos <= 5) first_step = first_step * 10 + (b - CH_ZERO);
              else final_step = final_step * 10 + (b - CH_ZERO);
              if (pos == 9 && (final_step < first_step ||
                               final_step - first_step + 1 > MAX_POINTS)) begin
                abandon(KIND_HEADER, b);
              end else begin
                if (pos == 9) bytes_left = 2 * (final_step - first_step + 1);
                pos++;
              end
            end
          end else if (pos >= HEADER_LAST) begin
            if (b != CH_LF) begin
              abandon(KIND_HEADER, b);
            end else begin
              phase = ST_DATA;
              point_count = 0;
              start_block();
            end
          end else begin
            pos++;
          end
        end
        ST_DATA: begin
          d = b - CH_ZERO;
          six = d[5:0];
          run_sum = run_sum + b[5:0];
          if (!bytes_left[0]) begin
            high_six = six;
          end else begin
            vals[fill & 31] = {high_six, six};
            fill = (fill + 1) & 63;
            point_count++;
          end
          if (bytes_left > 0) bytes_left--;
          pos++;
          if (pos >= BLOCK_BYTES || bytes_left == 0) phase = ST_CHECK;
        end
        ST_CHECK: begin
          if (b != {2'b00, run_sum} + CH_ZERO) begin
            abandon(KIND_CHECKSUM, b);
          end else begin
            // Block is good: release its points at their true scan position
            n = (fill > 32) ? 32 : fill;
            base = first_step + point_count - fill;
            for (int k = 0; k < n; k++) add_result(KIND_POINT, base + k, vals[k]);
            phase = ST_BLOCK_LF;
          end
        end
        ST_BLOCK_LF: begin
          if (b != CH_LF) begin
            abandon(KIND_FRAMING, b);
          end else if (bytes_left == 0) begin
            phase = ST_END_LF;
          end else begin
            phase = ST_DATA;
            start_block();
          end
        end
        ST_END_LF: begin
          if (b != CH_LF) begin
            abandon(KIND_FRAMING, b);
          end else begin
            phase = ST_HUNT_G;
            add_result(KIND_DONE, 0, 0);
          end
        end
        ST_HUNT_LF: begin
          if (b == CH_LF && prev_lf) begin
            phase = ST_HUNT_G;
            prev_lf = 1'b0;
          end else begin
            prev_lf = (b == CH_LF);
          end
        end
        default: begin
          phase = ST_HUNT_G;
          if (b == CH_G) begin
            phase = ST_HEADER;
            pos = 1;
            first_step = 0;
            final_step = 0;
          end
        end
      endcase
      foreach (batch[i]) begin
        r = batch[i];
        r.last = (i == batch.size() - 1);
        pending_results.push_back(r);
        kind_seen[int'(r.kind)]++;
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Called on every result transfer
    function void check_result(logic [2:0] k, logic [13:0] s, logic [11:0] d,
                               logic l);
      scan_result_t e;
      if (pending_results.size() == 0) begin
        flag($sformatf("result with nothing owed: kind %0d step %0d dist %0d last %0b",
                       k, s, d, l));
      end else begin
        e = pending_results.pop_front();
        if (k !== e.kind || s !== e.step || d !== e.dval || l !== e.last)
          flag($sformatf("exp kind %0d step %0d dist %0d last %0b, got %0d %0d %0d %0b",
                         e.kind, e.step, e.dval, e.last, k, s, d, l));
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        pop = 1'b0;
  logic        full, empty, last;
  logic [2:0]  kind;
  logic [13:0] step_index;
  logic [11:0] distance;

  scan_scoreboard sb;
  bit [7:0]       frame_bytes[$];
  bit             tx_burst = 1'b0;
  int             bytes_sent = 0;
  int             long_hold_req = 0;
  int             long_hold_done = 0;
  int             rx_hold = 0;
  int             rx_quiet_left = 0;
  int             cycles = 0;

  laser_scan_reply_parser #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .MAX_POINTS (MAX_POINTS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .rx_byte    (rx_byte),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .step_index (step_index),
    .distance   (distance),
    .last       (last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit [7:0] other_than(bit [7:0] x);
    bit [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == x);
    return c;
  endfunction

  function automatic bit [7:0] non_digit();
    bit [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
    return c;
  endfunction

  function automatic bit [7:0] data_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return CH_ZERO;
    if (r < 10) return CH_ZERO + 8'h3F;
    if (r < 85) return 8'($urandom_range(CH_ZERO, CH_ZERO + 8'h3F));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_digits(int unsigned v);
    frame_bytes.push_back(8'(CH_ZERO + (v / 1000) % 10));
    frame_bytes.push_back(8'(CH_ZERO + (v / 100) % 10));
    frame_bytes.push_back(8'(CH_ZERO + (v / 10) % 10));
    frame_bytes.push_back(8'(CH_ZERO + v % 10));
  endfunction

  // Builds one reply into frame_bytes; a fault cuts it at the bad byte and adds
  // a short non-LF tail followed by LF LF to end the hunt
  function automatic void build_frame(frame_fault_t fault, int npts, int start);
    int unsigned stop, total, idx, blk, sum, cut;
    int          sum_pos[$], lf_pos[$];
    bit [7:0]    c;
    frame_bytes = {};
    stop = start + npts - 1;
    if (fault == FLT_STEP_ORDER) begin
      start = $urandom_range(1, 9999);
      stop = $urandom_range(0, start - 1);
    end else if (fault == FLT_TOO_MANY) begin
      start = $urandom_range(0, 9999 - MAX_POINTS);
      stop = $urandom_range(0, 1) ? start + MAX_POINTS
                                  : $urandom_range(start + MAX_POINTS, 9999);
    end
    frame_bytes.push_back(CH_G);
    frame_bytes.push_back(CH_S);
    push_digits(start);
    push_digits(stop);
    repeat (12) frame_bytes.push_back(8'($urandom_range(0, 255)));
    frame_bytes.push_back(CH_LF);
    if (fault inside {FLT_NONE, FLT_CHECKSUM, FLT_BLOCK_LF, FLT_END_LF}) begin
      total = 2 * npts;
      idx = 0;
      while (idx < total) begin
        blk = (total - idx > BLOCK_BYTES) ? BLOCK_BYTES : total - idx;
        sum = 0;
        repeat (blk) begin
          c = data_char();
          sum += c;
          frame_bytes.push_back(c);
        end
        sum_pos.push_back(frame_bytes.size());
        frame_bytes.push_back(8'((sum & 8'h3F) + CH_ZERO));
        lf_pos.push_back(frame_bytes.size());
        frame_bytes.push_back(CH_LF);
        idx += blk;
      end
      frame_bytes.push_back(CH_LF);
    end
    cut = frame_bytes.size() - 1;
    case (fault)
      FLT_NOT_S: begin
        frame_bytes[1] = other_than(CH_S);
        cut = 1;
      end
      FLT_BAD_DIGIT: begin
        cut = $urandom_range(2, 9);
        frame_bytes[cut] = non_digit();
      end
      FLT_STEP_ORDER, FLT_TOO_MANY: cut = 9;
      FLT_HEADER_LF: begin
        cut = HEADER_LAST;
        frame_bytes[cut] = other_than(CH_LF);
      end
      FLT_CHECKSUM: begin
        cut = sum_pos[$urandom_range(0, sum_pos.size() - 1)];
        frame_bytes[cut] = other_than(frame_bytes[cut]);
      end
      FLT_BLOCK_LF: begin
        cut = lf_pos[$urandom_range(0, lf_pos.size() - 1)];
        frame_bytes[cut] = other_than(CH_LF);
      end
      FLT_END_LF: frame_bytes[cut] = other_than(CH_LF);
      default: ;
    endcase
    while (frame_bytes.size() > cut + 1) void'(frame_bytes.pop_back());
    if (fault != FLT_NONE) begin
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(other_than(CH_LF));
      frame_bytes.push_back(CH_LF);
      frame_bytes.push_back(CH_LF);
    end else begin
      // Line noise between replies
      repeat ($urandom_range(0, 2)) frame_bytes.push_back(other_than(CH_G));
    end
  endfunction

  // One byte transfer; push stays high straight into the next byte when no gap
  task automatic send_byte(bit [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full !== 1'b0);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Sender goes quiet until every owed result has come back
  task automatic wait_drained();
    int waited;
    waited = 0;
    push <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic int draw_rx_hold();
    if (rx_quiet_left > 0) begin
      rx_quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      rx_quiet_left = 30;
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Result receiver: per-result stall, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && empty === 1'b0) begin
        sb.check_result(kind, step_index, distance, last);
        rx_hold = draw_rx_hold();
      end
      if (long_hold_req != long_hold_done) begin
        long_hold_done++;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        pop <= 1'b0;
        rx_hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    frame_fault_t fault;
    int           npts, start, r, frame_no;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme noise bytes, header error on an LF with a one-LF hunt,
    // then a two-point reply at the top step range with extreme distances
    build_frame(FLT_NONE, 2, 9998);
    while (frame_bytes.size() > 30) void'(frame_bytes.pop_back());
    frame_bytes[23] = CH_ZERO + 8'h3F;
    frame_bytes[24] = CH_ZERO + 8'h3F;
    frame_bytes[25] = CH_ZERO;
    frame_bytes[26] = CH_ZERO;
    frame_bytes[27] = 8'((((CH_ZERO + 8'h3F) * 2 + CH_ZERO * 2) & 8'h3F) + CH_ZERO);
    frame_bytes.push_front(CH_LF);
    frame_bytes.push_front(CH_LF);
    frame_bytes.push_front(CH_S);
    frame_bytes.push_front(CH_G);
    frame_bytes.push_front(8'hFF);
    frame_bytes.push_front(8'h00);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);

    // Random replies, mostly well formed
    frame_no = 0;
    while (bytes_sent < BYTE_TARGET) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      if (frame_no == 1) begin
        // Receiver holds off while a multi-block reply streams in back to back
        long_hold_req++;
        tx_burst = 1'b1;
        build_frame(FLT_NONE, 100, $urandom_range(0, 10000 - 100));
        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
        wait_drained();
      end else begin
        r = $urandom_range(0, 99);
        fault = (r < 60) ? FLT_NONE : frame_fault_t'($urandom_range(1, 8));
        r = $urandom_range(0, 99);
        if (r < 55) npts = $urandom_range(1, 8);
        else if (r < 85) npts = $urandom_range(9, 40);
        else npts = $urandom_range(41, 100);
        // Keep the last reply from running far past the byte budget
        if (npts > (BYTE_TARGET - bytes_sent) / 2 + 1)
          npts = (BYTE_TARGET - bytes_sent) / 2 + 1;
        case ($urandom_range(0, 3))
          0: start = 0;
          1: start = 10000 - npts;
          default: start = $urandom_range(0, 10000 - npts);
        endcase
        build_frame(fault, npts, start);
        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
      frame_no++;
    end
    push <= 1'b0;

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) sb.flag($sformatf("%0d results never arrived", sb.pending()));

    $display("Sent %0d bytes over %0d replies; checked %0d points, %0d frame ends.",
             bytes_sent, frame_no + 1, sb.kind_seen[KIND_POINT], sb.kind_seen[KIND_DONE]);
    $display("Errors exercised: %0d header, %0d checksum, %0d framing; %0d failures.",
             sb.kind_seen[KIND_HEADER], sb.kind_seen[KIND_CHECKSUM],
             sb.kind_seen[KIND_FRAMING], sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
